/* rtl/modular_inverse_ext_euclid_top_defines.svh */
// Assertion macros for the modular inverse block.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge, off while in reset.
`define MIE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("modular inverse check failed");
// Implication of the form a |-> b.
`define MIE_ASSERT_IMP(lbl, ante, cons) \
  `MIE_ASSERT(lbl, (ante) |-> (cons))
`else
`define MIE_ASSERT(lbl, prop)
`define MIE_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

/* rtl/mie_pkg.sv */
// Package for the modular inverse block: defaults and sequencer states.
package mie_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int MOD_RESET = 7919;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_UPD  = 6'b000100,
    S_STEP = 6'b001000,
    S_FIX  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

endpackage

/* rtl/modular_inverse_ext_euclid_top.sv */
// Modular inverse by the extended Euclidean algorithm, iterative datapath.
//
// Use:
//   Configuration: cfg_we_i/cfg_wdata_i write the modulus (reset 7919). Write
//   it only while the block is idle and no word is in flight.
//   Input: value_valid_i/value_ready_o carry one word, value_i. Ready is high
//   only while the sequencer is idle; one word is worked on at a time.
//   Output: result_valid_o/result_ready_i carry inverse_o and no_inverse_o.
//   The result sits in an output register, so the next word may be accepted
//   while it waits; the sequencer only holds in its last state if a second
//   result is finished before the first was taken.
// Sequence (W = WIDTH):
//   The value is first reduced modulo the modulus by a pass of the shared
//   shift-subtract divider, then each Euclid step takes a pass of the same
//   divider (quotient bits MSB first, the coefficient product built alongside
//   by shift-add) followed by the update state and the test state.
//   The number of Euclid steps is at most about 1.44 * W. Without an inverse
//   the fix-up state is skipped; a modulus below two goes from idle straight
//   to the output state. Ready for the next word rises with result valid.
// Reset: asynchronous, active low; clears sequencer and output valid, loads the modulus.
module modular_inverse_ext_euclid_top #(
  parameter int WIDTH = mie_pkg::WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  input  logic             value_valid_i,
  output logic             value_ready_o,
  input  logic [WIDTH-1:0] value_i,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);

  import mie_pkg::*;

  localparam int CntW = $clog2(WIDTH);
  localparam int MW   = WIDTH + 1;   // coefficient magnitudes, one spare bit

  state_e           state_q;
  logic [WIDTH-1:0] mod_q;     // configured modulus
  logic [WIDTH-1:0] m_q;       // modulus captured for the word at work
  logic [WIDTH-1:0] r0_q, r1_q;
  logic [WIDTH-1:0] dvd_q, rem_q;
  logic [MW-1:0]    mag0_q, mag1_q, prod_q;
  logic             neg0_q, neg1_q;
  logic             red_q;     // divider pass is the initial reduction
  logic             fail_q;
  logic [CntW-1:0]  cnt_q;
  logic [WIDTH-1:0] inv_q;
  logic             noinv_q, ovalid_q;

  // Shared divider step: one quotient bit and one shift-add of the product.
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] diff;
  logic             qbit;
  logic [WIDTH-1:0] rem_d;
  logic [MW-1:0]    prod_d;
  logic [MW-1:0]    mag_sum;
  logic [MW-1:0]    mag_red;
  logic [MW-1:0]    m_ext;
  logic             out_free;

  assign rem_sh  = {rem_q, dvd_q[WIDTH-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, r1_q};
  assign qbit    = ~diff[WIDTH+1];
  assign rem_d   = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  assign prod_d  = {prod_q[MW-2:0], 1'b0} + (qbit ? mag1_q : '0);
  assign mag_sum = mag0_q + prod_q;
  assign m_ext   = {1'b0, m_q};
  // the final coefficient never exceeds the modulus, one subtract suffices
  assign mag_red = (mag0_q >= m_ext) ? (mag0_q - m_ext) : mag0_q;
  assign out_free = ~ovalid_q | result_ready_i;

  assign value_ready_o  = (state_q == S_IDLE);
  assign result_valid_o = ovalid_q;
  assign inverse_o      = inv_q;
  assign no_inverse_o   = noinv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WIDTH'(MOD_RESET);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      ovalid_q <= 1'b1;
    end else if (result_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      red_q   <= 1'b0;
      fail_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (value_valid_i) begin
            m_q <= mod_q;
            if (mod_q < WIDTH'(2)) begin
              fail_q  <= 1'b1;
              state_q <= S_OUT;
            end else begin
              fail_q  <= 1'b0;
              red_q   <= 1'b1;
              r1_q    <= mod_q;
              dvd_q   <= value_i;
              rem_q   <= '0;
              prod_q  <= '0;
              cnt_q   <= CntW'(WIDTH - 1);
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= rem_d;
          dvd_q  <= {dvd_q[WIDTH-2:0], 1'b0};
          prod_q <= prod_d;
          cnt_q  <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          r1_q <= rem_q;
          if (red_q) begin
            red_q  <= 1'b0;
            r0_q   <= m_q;
            mag0_q <= '0;
            mag1_q <= MW'(1);
            neg0_q <= 1'b1;
            neg1_q <= 1'b0;
          end else begin
            r0_q   <= r1_q;
            mag0_q <= mag1_q;
            mag1_q <= mag_sum;
            neg0_q <= neg1_q;
            neg1_q <= ~neg1_q;
          end
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (r1_q != '0) begin
            dvd_q   <= r0_q;
            rem_q   <= '0;
            prod_q  <= '0;
            cnt_q   <= CntW'(WIDTH - 1);
            state_q <= S_DIV;
          end else if (r0_q != WIDTH'(1)) begin
            fail_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            mag0_q  <= mag_red;
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          // negative coefficient folds back into 0..m-1
          if (neg0_q && mag0_q != '0) begin
            mag0_q <= m_ext - mag0_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            inv_q   <= fail_q ? '0 : mag0_q[WIDTH-1:0];
            noinv_q <= fail_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`include "modular_inverse_ext_euclid_top_defines.svh"

  `MIE_ASSERT_IMP(a_noinv_zero, result_valid_o && no_inverse_o, inverse_o == '0)
  `MIE_ASSERT_IMP(a_inv_range, result_valid_o && !no_inverse_o, inverse_o < m_q)
  `MIE_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, r1_q != '0)
  `MIE_ASSERT_IMP(a_rem_below, state_q == S_DIV, rem_q < r1_q)

endmodule

/* tb/modular_inverse_ext_euclid_top_tb.sv */
// Self-checking testbench for the modular inverse block: stimulus, prediction and checks.
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_top_tb;

  localparam int W = mie_pkg::WIDTH_DEF;

  // The longest Euclid chain at W = 16 is about 24 steps, each a divider pass
  // plus the update and test states; the reduction pass and final states add on.
  localparam int TAIL_CYCLES    = 500;
  localparam int HOLD_CYCLES    = 1500;   // long receiver hold-off, forces a full stall
  localparam int HOLD_AFTER     = 300;    // results taken before the hold-off starts
  localparam int WATCHDOG_LIMIT = 10000;  // cycles with no word moving on either side
  localparam int N_PHASES       = 11;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         no_inverse;
  } inv_result_t;

  typedef struct {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    inv_result_t  want;
  } awaited_t;

  logic         clk_i          = 1'b0;
  logic         rst_ni         = 1'b0;
  logic         cfg_we_i       = 1'b0;
  logic [W-1:0] cfg_wdata_i    = '0;
  logic         value_valid_i  = 1'b0;
  logic         value_ready_o;
  logic [W-1:0] value_i        = '0;
  logic         result_valid_o;
  logic         result_ready_i = 1'b0;
  logic [W-1:0] inverse_o;
  logic         no_inverse_o;

  // Values waiting to be offered, and predicted results in order of acceptance.
  logic [W-1:0] pending_values[$];
  awaited_t     awaited_inverses[$];

  // Testbench copy of the modulus register; only changed while the block is idle.
  logic [W-1:0] cur_modulus = W'(mie_pkg::MOD_RESET);

  // Both sides run without gaps while this is set.
  bit calm = 1'b0;

  int unsigned items_sent      = 0;
  int unsigned results_taken   = 0;
  int unsigned no_inverse_seen = 0;
  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;
  int unsigned send_gap        = 0;
  int unsigned take_gap        = 0;
  int unsigned stall_left      = 0;
  bit          held_off        = 1'b0;

  modular_inverse_ext_euclid_top #(
    .WIDTH(W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .value_valid_i (value_valid_i),
    .value_ready_o (value_ready_o),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .inverse_o     (inverse_o),
    .no_inverse_o  (no_inverse_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Extended Euclid: remainder chain with the value's coefficient carried as a
  // magnitude whose sign flips at each step. Divisor one at the end means an
  // inverse exists; the coefficient is then folded into 0..m-1.
  function automatic inv_result_t mod_inverse(logic [W-1:0] v, logic [W-1:0] m);
    logic [63:0] r_prev, r_cur, r_next, quo, c_prev, c_cur, c_next;
    logic        neg_prev, neg_cur;
    inv_result_t res;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    if (m < 2) return res;
    r_prev   = 64'(m);
    r_cur    = 64'(v) % 64'(m);
    c_prev   = 0;
    c_cur    = 1;
    neg_prev = 1'b1;
    neg_cur  = 1'b0;
    while (r_cur != 0) begin
      quo      = r_prev / r_cur;
      r_next   = r_prev - quo * r_cur;
      c_next   = c_prev + quo * c_cur;
      r_prev   = r_cur;
      r_cur    = r_next;
      c_prev   = c_cur;
      c_cur    = c_next;
      neg_prev = neg_cur;
      neg_cur  = !neg_cur;
    end
    if (r_prev != 1) return res;
    c_prev         = c_prev % 64'(m);
    res.no_inverse = 1'b0;
    res.inverse    = (neg_prev && c_prev != 0) ? W'(64'(m) - c_prev) : W'(c_prev);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  // Random value with a bias towards the interesting corners: below the
  // modulus, multiples of it, multiples of one of its small factors, tiny
  // values, and values just around the top or around the modulus.
  function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
    logic [W-1:0] v;
    int unsigned  sel, f;
    sel = $urandom_range(0, 9);
    v   = W'($urandom);
    case (sel)
      4, 5: if (m != 0) v = W'($urandom % m);
      6: v = W'(m * $urandom_range(0, 8));
      7: begin
        f = $urandom_range(2, 17);
        if (m != 0 && m % f == 0) v = W'(f * $urandom_range(1, 3000));
      end
      8: v = W'($urandom_range(0, 20));
      9: v = ($urandom_range(0, 3) == 0) ? W'(16'hFFFF - $urandom_range(0, 15))
                                         : W'(m + $urandom_range(0, 2) - 1);
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string field, awaited_t exp_item, int unsigned got,
                                 int unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH %s: value %0d mod %0d got %0d want %0d",
               field, exp_item.value, exp_item.modulus, got, want);
    mismatches++;
  endtask

  // Driver: offers the next pending value, holds it until taken, and logs the
  // predicted result at the edge where the word is accepted.
  always @(posedge clk_i) begin
    awaited_t accepted;
    if (!rst_ni) begin
      value_valid_i <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (value_valid_i && value_ready_o) begin
        accepted         = '{value_i, cur_modulus, mod_inverse(value_i, cur_modulus)};
        awaited_inverses = {awaited_inverses, accepted};
        items_sent++;
      end
      if (!value_valid_i || value_ready_o) begin
        if (send_gap != 0) begin
          value_valid_i <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pending_values.size() != 0) begin
          value_valid_i <= 1'b1;
          value_i       <= pending_values.pop_front();
          send_gap      <= calm ? 0 : gap_len();
        end else begin
          value_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random gaps, plus one long hold-off once enough results
  // have come, while the driver keeps offering so the block backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      result_ready_i <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!held_off && results_taken >= HOLD_AFTER) begin
      result_ready_i <= 1'b0;
      stall_left     <= HOLD_CYCLES;
      held_off       <= 1'b1;
    end else if (take_gap != 0) begin
      result_ready_i <= 1'b0;
      take_gap       <= take_gap - 1;
    end else begin
      result_ready_i <= 1'b1;
      take_gap       <= calm ? 0 : gap_len();
    end
  end

  // Monitor: every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    awaited_t exp_item;
    if (rst_ni && result_valid_o && result_ready_i) begin
      results_taken++;
      if (no_inverse_o) no_inverse_seen++;
      if (awaited_inverses.size() == 0) begin
        exp_item = '{'0, cur_modulus, '0};
        report_mismatch("unexpected word", exp_item, inverse_o, 0);
      end else begin
        exp_item = awaited_inverses.pop_front();
        if (inverse_o !== exp_item.want.inverse)
          report_mismatch("inverse", exp_item, inverse_o, exp_item.want.inverse);
        if (no_inverse_o !== exp_item.want.no_inverse)
          report_mismatch("no_inverse", exp_item, no_inverse_o, exp_item.want.no_inverse);
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (value_valid_i && value_ready_o) || (result_valid_o && result_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Phases: each picks a modulus (written while idle), queues directed and
  // random values, then waits for every result before moving on.
  initial begin
    logic [W-1:0] m;
    int unsigned  n_rand;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin m = W'(mie_pkg::MOD_RESET); n_rand = 200; end
        1:       begin m = 16'hFFFF;               n_rand = 200; end
        2:       begin m = W'(2);                  n_rand = 40;  end
        3:       begin m = W'(65521);              n_rand = 200; end  // largest 16-bit prime
        4:       begin m = W'(1);                  n_rand = 20;  end  // below range: never invertible
        5:       begin m = W'(0);                  n_rand = 20;  end
        6:       begin m = W'(256);                n_rand = 150; end
        8:       begin m = W'($urandom_range(2, 300)); n_rand = 200; end
        9:       begin m = W'(12);                 n_rand = 100; end
        default: begin m = W'($urandom_range(2, 65535)); n_rand = (p == 10) ? 250 : 200; end
      endcase
      calm = (p % 4 == 2);

      // Phase 0 runs on the reset value of the modulus.
      if (p != 0) begin
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= m;
        cur_modulus  = m;
        @(posedge clk_i);
        cfg_we_i    <= 1'b0;
      end

      // Directed corners: zero, one, minus one, multiples, values above the
      // modulus that reduce to one, and the field extremes.
      if (p == 0)
        pending_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd7918, 16'd7919, 16'd7920,
                           16'd15838, 16'h8000, 16'hFFFF, 16'hFFFE};
      if (p == 1)  // composite modulus 3 * 5 * 17 * 257
        pending_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd17, 16'd257,
                           16'h8000, 16'hFFFE, 16'hFFFF};
      for (int i = 0; i < n_rand; i++) pending_values = {pending_values, pick_value(m)};

      while (pending_values.size() != 0 || value_valid_i || awaited_inverses.size() != 0)
        @(posedge clk_i);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d values over %0d moduli, %0d results, %0d without an inverse.",
             items_sent, N_PHASES, results_taken, no_inverse_seen);
    $display("Long receiver hold-off of %0d cycles applied: %0d; mismatches: %0d.",
             HOLD_CYCLES, held_off, mismatches);
    if (mismatches == 0 && awaited_inverses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mie_pkg.sv
rtl/modular_inverse_ext_euclid_top.sv
tb/modular_inverse_ext_euclid_top_tb.sv
